// ===== src/lobm_pkg.sv =====
// Shared constants and types for the order book matcher.
`default_nettype none
package lobm_pkg;

  localparam int unsigned BookDepth = 1024;
  localparam int unsigned CntW      = $clog2(BookDepth + 1);
  localparam int unsigned FieldW    = 30;
  localparam logic [FieldW-1:0] Modulus = 30'd1000000007;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2,
    OP_ADJ    = 2'd3
  } book_op_e;

  // Command broadcast to every cell of one book
  typedef struct packed {
    book_op_e          op;
    logic [FieldW-1:0] price;
    logic [FieldW-1:0] amount;
  } book_cmd_t;

  // Head-of-book status returned to the sequencer
  typedef struct packed {
    logic              valid;
    logic              full;
    logic [FieldW-1:0] price;
    logic [FieldW-1:0] amount;
  } book_stat_t;

endpackage
`default_nettype wire

// ===== src/lobm_cell.sv =====
// One slot of a sorted order book; shifts with its neighbors on insert and pop.
`default_nettype none
module lobm_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire lobm_pkg::book_cmd_t           cmd_i,
  input  wire logic                          asc_i,
  input  wire logic                          head_i,
  input  wire logic                          left_bef_i,
  input  wire logic                          left_valid_i,
  input  wire logic [lobm_pkg::FieldW-1:0]   left_price_i,
  input  wire logic [lobm_pkg::FieldW-1:0]   left_amount_i,
  input  wire logic                          right_valid_i,
  input  wire logic [lobm_pkg::FieldW-1:0]   right_price_i,
  input  wire logic [lobm_pkg::FieldW-1:0]   right_amount_i,
  output logic                               valid_o,
  output logic [lobm_pkg::FieldW-1:0]        price_o,
  output logic [lobm_pkg::FieldW-1:0]        amount_o,
  output logic                               bef_o
);

  logic                        valid_q, valid_d;
  logic [lobm_pkg::FieldW-1:0] price_q, price_d;
  logic [lobm_pkg::FieldW-1:0] amount_q, amount_d;

  // New order goes ahead of this slot: slot empty or strictly worse price
  assign bef_o = !valid_q || (asc_i ? (price_q > cmd_i.price) : (price_q < cmd_i.price));

  always_comb begin
    valid_d  = valid_q;
    price_d  = price_q;
    amount_d = amount_q;
    case (cmd_i.op)
      lobm_pkg::OP_INSERT: begin
        if (bef_o) begin
          if (head_i || !left_bef_i) begin
            valid_d  = 1'b1;
            price_d  = cmd_i.price;
            amount_d = cmd_i.amount;
          end else begin
            valid_d  = left_valid_i;
            price_d  = left_price_i;
            amount_d = left_amount_i;
          end
        end
      end
      lobm_pkg::OP_POP: begin
        valid_d  = right_valid_i;
        price_d  = right_price_i;
        amount_d = right_amount_i;
      end
      lobm_pkg::OP_ADJ: begin
        if (head_i) begin
          amount_d = cmd_i.amount;
        end
      end
      default: begin
      end
    endcase
  end

  // Valid bit is control; price and amount are payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q  <= price_d;
    amount_q <= amount_d;
  end

  assign valid_o  = valid_q;
  assign price_o  = price_q;
  assign amount_o = amount_q;

endmodule
`default_nettype wire

// ===== src/lobm_book.sv =====
// One side of the book: a row of cells kept sorted by price, then by age.
`default_nettype none
module lobm_book (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                asc_i,
  input  wire lobm_pkg::book_cmd_t cmd_i,
  output lobm_pkg::book_stat_t     stat_o
);

  localparam int unsigned Depth = lobm_pkg::BookDepth;

  logic                        valid [Depth];
  logic [lobm_pkg::FieldW-1:0] price [Depth];
  logic [lobm_pkg::FieldW-1:0] amount [Depth];
  logic                        bef [Depth];

  logic [lobm_pkg::CntW-1:0] count_q, count_d;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic                        lb, lv, rv;
    logic [lobm_pkg::FieldW-1:0] lp, la, rp, ra;
    if (i == 0) begin : g_first
      assign lb = 1'b0;
      assign lv = 1'b0;
      assign lp = '0;
      assign la = '0;
    end else begin : g_mid
      assign lb = bef[i-1];
      assign lv = valid[i-1];
      assign lp = price[i-1];
      assign la = amount[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign rv = 1'b0;
      assign rp = '0;
      assign ra = '0;
    end else begin : g_inner
      assign rv = valid[i+1];
      assign rp = price[i+1];
      assign ra = amount[i+1];
    end
    lobm_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd_i),
      .asc_i         (asc_i),
      .head_i        (i == 0),
      .left_bef_i    (lb),
      .left_valid_i  (lv),
      .left_price_i  (lp),
      .left_amount_i (la),
      .right_valid_i (rv),
      .right_price_i (rp),
      .right_amount_i(ra),
      .valid_o       (valid[i]),
      .price_o       (price[i]),
      .amount_o      (amount[i]),
      .bef_o         (bef[i])
    );
  end

  // Entry count, used only for the full check
  always_comb begin
    count_d = count_q;
    case (cmd_i.op)
      lobm_pkg::OP_INSERT: count_d = count_q + 1'b1;
      lobm_pkg::OP_POP:    count_d = count_q - 1'b1;
      default:             count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign stat_o.valid  = valid[0];
  assign stat_o.full   = (count_q == lobm_pkg::CntW'(Depth));
  assign stat_o.price  = price[0];
  assign stat_o.amount = amount[0];

endmodule
`default_nettype wire

// ===== src/limit_order_book_matcher.sv =====
// Top level: order sequencer, backlog modulo tracking and two cell-row books.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o | side_i, price_i, amount_i
//   out     | output    | out_valid_o / out_stall_i | backlog_mod_o, rejected_o
//
// An order passes through the match, rest and done states; in the match state it
// trades one match per cycle at the head cell of the opposite book.
// Both books are rows of sorted cells, so insert and pop shift all cells at once.
// Reset clears the cell valid bits and counters at once; no clearing pass.
// A finished result waits in the output register while out_stall_i is high.
`default_nettype none
module limit_order_book_matcher (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        side_i,
  input  wire logic [lobm_pkg::FieldW-1:0] price_i,
  input  wire logic [lobm_pkg::FieldW-1:0] amount_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [lobm_pkg::FieldW-1:0]      backlog_mod_o,
  output logic                             rejected_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MATCH = 4'b0010,
    ST_REST  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  localparam logic [lobm_pkg::FieldW:0] ModW = {1'b0, lobm_pkg::Modulus};

  state_e                      state_q, state_d;
  logic                        side_q, side_d;
  logic [lobm_pkg::FieldW-1:0] price_q, price_d;
  logic [lobm_pkg::FieldW-1:0] rem_q, rem_d;
  logic                        rej_q, rej_d;
  logic [lobm_pkg::FieldW-1:0] mod_q, mod_d;
  logic                        oval_q, oval_d;
  logic [lobm_pkg::FieldW-1:0] omod_q, omod_d;
  logic                        orej_q, orej_d;

  lobm_pkg::book_cmd_t  buy_cmd, sell_cmd, opp_cmd, own_cmd;
  lobm_pkg::book_stat_t buy_stat, sell_stat, opp_stat, own_stat;

  logic                        crosses;
  logic [lobm_pkg::FieldW-1:0] k, kr, rr;
  logic [lobm_pkg::FieldW:0]   sub_w, add_w;

  assign opp_stat = side_q ? buy_stat : sell_stat;
  assign own_stat = side_q ? sell_stat : buy_stat;
  assign crosses  = side_q ? (opp_stat.price >= price_q) : (opp_stat.price <= price_q);

  // Trade size and its reduction modulo the constant
  assign k  = (rem_q < opp_stat.amount) ? rem_q : opp_stat.amount;
  assign kr = (k >= lobm_pkg::Modulus) ? (k - lobm_pkg::Modulus) : k;
  assign rr = (rem_q >= lobm_pkg::Modulus) ? (rem_q - lobm_pkg::Modulus) : rem_q;
  assign sub_w = (mod_q >= kr) ? {1'b0, mod_q - kr} : ({1'b0, mod_q} + ModW - {1'b0, kr});
  assign add_w = {1'b0, mod_q} + {1'b0, rr};

  // Sequencer
  always_comb begin
    state_d = state_q;
    side_d  = side_q;
    price_d = price_q;
    rem_d   = rem_q;
    rej_d   = rej_q;
    mod_d   = mod_q;
    oval_d  = oval_q && out_stall_i;
    omod_d  = omod_q;
    orej_d  = orej_q;
    opp_cmd = '{op: lobm_pkg::OP_NONE, price: price_q, amount: rem_q};
    own_cmd = '{op: lobm_pkg::OP_NONE, price: price_q, amount: rem_q};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          side_d  = side_i;
          price_d = price_i;
          rem_d   = amount_i;
          rej_d   = 1'b0;
          state_d = ST_MATCH;
        end
      end
      ST_MATCH: begin
        if (rem_q == '0 || !opp_stat.valid || !crosses) begin
          state_d = ST_REST;
        end else begin
          rem_d = rem_q - k;
          mod_d = sub_w[lobm_pkg::FieldW-1:0];
          if (opp_stat.amount == k) begin
            opp_cmd.op = lobm_pkg::OP_POP;
          end else begin
            opp_cmd.op     = lobm_pkg::OP_ADJ;
            opp_cmd.amount = opp_stat.amount - k;
          end
        end
      end
      ST_REST: begin
        if (rem_q != '0) begin
          if (own_stat.full) begin
            rej_d = 1'b1;
          end else begin
            own_cmd.op = lobm_pkg::OP_INSERT;
            mod_d = (add_w >= ModW) ? (add_w[lobm_pkg::FieldW-1:0] - lobm_pkg::Modulus)
                                    : add_w[lobm_pkg::FieldW-1:0];
          end
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!oval_q || !out_stall_i) begin
          oval_d  = 1'b1;
          omod_d  = mod_q;
          orej_d  = rej_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    buy_cmd  = side_q ? opp_cmd : own_cmd;
    sell_cmd = side_q ? own_cmd : opp_cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mod_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mod_q   <= mod_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q  <= side_d;
    price_q <= price_d;
    rem_q   <= rem_d;
    rej_q   <= rej_d;
    omod_q  <= omod_d;
    orej_q  <= orej_d;
  end

  lobm_book u_buy (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .asc_i (1'b0),
    .cmd_i (buy_cmd),
    .stat_o(buy_stat)
  );

  lobm_book u_sell (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .asc_i (1'b1),
    .cmd_i (sell_cmd),
    .stat_o(sell_stat)
  );

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = oval_q;
  assign backlog_mod_o = omod_q;
  assign rejected_o    = orej_q;

endmodule
`default_nettype wire

// ===== bench/limit_order_book_matcher_tb.sv =====
// Testbench for the order book matcher: directed table, random orders, book-full stress.
`timescale 1ns / 100ps
`default_nettype none
module limit_order_book_matcher_tb;

  localparam int unsigned FieldW    = lobm_pkg::FieldW;
  localparam int unsigned BookDepth = lobm_pkg::BookDepth;
  localparam int unsigned IdleLimit = 40000;
  localparam int unsigned NumRandom = 130;
  localparam int unsigned NumFill   = 1040;
  localparam logic [FieldW-1:0] FieldMax = {FieldW{1'b1}};
  localparam logic SideBuy  = 1'b0;
  localparam logic SideSell = 1'b1;

  typedef struct {
    logic              side;
    logic [FieldW-1:0] price;
    logic [FieldW-1:0] amount;
    bit                typed;
    logic [FieldW-1:0] backlog;
    logic              rejected;
  } order_row_t;

  typedef struct {
    logic [FieldW-1:0] backlog;
    logic              rejected;
  } book_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              side = 1'b0;
  logic [FieldW-1:0] price = '0;
  logic [FieldW-1:0] amount = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [FieldW-1:0] backlog_mod;
  logic              rejected;

  // Predictor state: index 0 is the buy book, index 1 the sell book
  logic [FieldW-1:0] book_price [2][BookDepth];
  logic [FieldW-1:0] book_amount[2][BookDepth];
  int unsigned       book_count [2];
  longint unsigned   resting_total;

  book_result_t pending_results[$];
  int unsigned  fails = 0;
  int unsigned  idle_cycles = 0;
  bit           calm = 1'b0;
  order_row_t   rows[$];

  limit_order_book_matcher u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .side_i       (side),
    .price_i      (price),
    .amount_i     (amount),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .backlog_mod_o(backlog_mod),
    .rejected_o   (rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fails++;
  endtask

  // Match an order against the opposite book, then rest or drop the remainder
  function automatic book_result_t match_order(input logic s, input logic [FieldW-1:0] p,
                                               input logic [FieldW-1:0] a);
    book_result_t res;
    int unsigned opp;
    int unsigned best;
    logic [FieldW-1:0] rem;
    logic [FieldW-1:0] take;
    bit crosses;
    opp = s ? 0 : 1;
    rem = a;
    res.rejected = 1'b0;
    while (rem != 0 && book_count[opp] != 0) begin
      best = 0;
      for (int unsigned i = 1; i < book_count[opp]; i++) begin
        if (s ? (book_price[opp][i] > book_price[opp][best])
              : (book_price[opp][i] < book_price[opp][best]))
          best = i;
      end
      crosses = s ? (book_price[opp][best] >= p) : (book_price[opp][best] <= p);
      if (!crosses) break;
      take = (rem < book_amount[opp][best]) ? rem : book_amount[opp][best];
      rem -= take;
      book_amount[opp][best] -= take;
      resting_total -= take;
      if (book_amount[opp][best] == 0) begin
        for (int unsigned i = best; i + 1 < book_count[opp]; i++) begin
          book_price[opp][i]  = book_price[opp][i+1];
          book_amount[opp][i] = book_amount[opp][i+1];
        end
        book_count[opp]--;
      end
    end
    if (rem != 0) begin
      if (book_count[s] < BookDepth) begin
        book_price[s][book_count[s]]  = p;
        book_amount[s][book_count[s]] = rem;
        book_count[s]++;
        resting_total += rem;
      end else begin
        res.rejected = 1'b1;
      end
    end
    res.backlog = FieldW'(resting_total % 64'd1000000007);
    return res;
  endfunction

  // Mostly short gaps, a few long ones, none in calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 50) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_order(input logic s, input logic [FieldW-1:0] p,
                            input logic [FieldW-1:0] a, output book_result_t res);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    side     <= s;
    price    <= p;
    amount   <= a;
    do @(posedge clk); while (in_stall);
    res = match_order(s, p, a);
    pending_results.push_back(res);
  endtask

  function automatic order_row_t row(input logic s, input logic [FieldW-1:0] p,
                                     input logic [FieldW-1:0] a, input bit t = 0,
                                     input logic [FieldW-1:0] b = '0, input logic r = 0);
    order_row_t o;
    o = '{s, p, a, t, b, r};
    return o;
  endfunction

  // Result side: compare each accepted result and pick the next stall
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    book_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        if (backlog_mod !== want.backlog)
          report($sformatf("backlog_mod %0d, expected %0d", backlog_mod, want.backlog));
        if (rejected !== want.rejected)
          report($sformatf("rejected %0b, expected %0b", rejected, want.rejected));
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm || $urandom_range(99) < 60) begin
      out_stall <= 1'b0;
    end else begin
      stall_left = ($urandom_range(99) < 90) ? $urandom_range(2) : $urandom_range(60, 20);
      out_stall <= 1'b1;
    end
  end

  // Watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("limit_order_book_matcher test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    book_result_t got;
    logic s;
    logic [FieldW-1:0] p;
    logic [FieldW-1:0] a;
    int unsigned r;
    book_count[0] = 0;
    book_count[1] = 0;
    resting_total = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: crossing, ties, zero fields and extremes
    rows.push_back(row(SideBuy,  5, 10, 1, 10, 0));
    rows.push_back(row(SideSell, 6, 3,  1, 13, 0));
    rows.push_back(row(SideSell, 5, 4,  1, 9,  0));
    rows.push_back(row(SideBuy,  0, 0,  1, 9,  0));
    rows.push_back(row(SideSell, 0, 0,  1, 9,  0));
    rows.push_back(row(SideBuy,  FieldMax, FieldMax));
    rows.push_back(row(SideSell, FieldMax, FieldMax));
    rows.push_back(row(SideSell, 0, FieldMax));
    rows.push_back(row(SideBuy,  7, 2));
    rows.push_back(row(SideBuy,  7, 3));
    rows.push_back(row(SideBuy,  7, 4));
    rows.push_back(row(SideSell, 7, 2));
    rows.push_back(row(SideSell, 7, 4));
    rows.push_back(row(SideSell, 8, 5));
    rows.push_back(row(SideSell, 8, 6));
    rows.push_back(row(SideBuy,  8, 7));
    rows.push_back(row(SideBuy,  FieldMax, 1));
    rows.push_back(row(SideSell, 1, 30'h2AAAAAAA));
    rows.push_back(row(SideBuy,  30'h15555555, 30'h15555555));
    rows.push_back(row(SideSell, 0, 30'd1000000007));
    foreach (rows[i]) begin
      send_order(rows[i].side, rows[i].price, rows[i].amount, got);
      if (rows[i].typed && (got.backlog !== rows[i].backlog || got.rejected !== rows[i].rejected))
        report($sformatf("row %0d predicted %0d/%0b, table %0d/%0b", i, got.backlog,
                         got.rejected, rows[i].backlog, rows[i].rejected));
    end

    // Random orders: mostly a narrow price band so books cross often
    for (int unsigned n = 0; n < NumRandom; n++) begin
      calm = (n / 40) % 3 == 2;
      r = $urandom_range(99);
      s = $urandom_range(1);
      if (r < 85) begin
        p = $urandom_range(1020, 1000);
        a = ($urandom_range(9) == 0) ? $urandom_range(1000000000, 1) : $urandom_range(100, 1);
      end else begin
        p = $urandom();
        a = $urandom();
      end
      send_order(s, p, a, got);
    end

    // Fill the buy book past its depth so remainders get dropped
    calm = 1'b0;
    for (int unsigned n = 0; n < NumFill; n++)
      send_order(SideBuy, $urandom_range(3, 1), $urandom_range(1000, 1), got);
    // Sweep a full book, then refill it by one
    send_order(SideSell, 0, FieldMax, got);
    send_order(SideBuy, FieldMax, FieldMax, got);
    send_order(SideBuy, 2, 5, got);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0)
      $display("limit_order_book_matcher test passed");
    else
      $display("limit_order_book_matcher test failed");
    $finish;
  end

endmodule
`default_nettype wire
